/* hw/rtl/swmd_pkg.sv */
// shared types and constants for the sliding window median deviation sum
package swmd_pkg;

  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int SAMPLE_W        = 16;
  localparam int COST_W          = 21;
  localparam int WSIZE_W         = 7;
  localparam int IN_TDATA_W      = 16;
  localparam int OUT_TDATA_W     = 24;
  localparam int CFG_DATA_W      = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DONE
  } state_t;

  // control broadcast to every cell of the sorted row
  typedef struct packed {
    logic ins;       // insert the new word this cycle
    logic del_any;   // the oldest entry leaves the row
    logic del_low;   // leaving entry sits below the insert point
    logic load;      // copy the row into the scan line
    logic shift;     // move the scan line one cell toward cell zero
  } cell_ctrl_t;

endpackage

/* hw/rtl/swmd_cell.sv */
// one cell of the sorted row: value, age and its scan-line stage
module swmd_cell #(
  parameter int SB = 16,
  parameter int AW = 6,
  parameter int CW = 7,
  parameter int WMAX = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  swmd_pkg::cell_ctrl_t  ctrl,
  input  logic [SB-1:0]         new_val,
  input  logic [CW-1:0]         win,
  input  logic [SB-1:0]         left_val,
  input  logic [AW-1:0]         left_age,
  input  logic                  left_valid,
  input  logic                  left_g,
  input  logic [SB-1:0]         right_val,
  input  logic [AW-1:0]         right_age,
  input  logic                  right_valid,
  input  logic                  right_g,
  input  logic                  del_before,
  input  logic                  del_at_or_before,
  input  logic [SB-1:0]         scan_in_val,
  input  logic                  scan_in_act,
  output logic [SB-1:0]         val,
  output logic [AW-1:0]         age,
  output logic                  valid,
  output logic                  g,
  output logic                  del,
  output logic [SB-1:0]         scan_val,
  output logic                  scan_act
);
  import swmd_pkg::*;

  logic [SB-1:0] val_next;
  logic [AW-1:0] age_next;
  logic          valid_next;

  // compare against the incoming word and flag the entry that ages out
  assign g   = !valid || (val > new_val);
  assign del = valid && (age == AW'(WMAX - 1));

  // choose keep, take new, take left or take right
  always_comb begin
    val_next   = val;
    age_next   = age + AW'(1);
    valid_next = valid;
    if (!ctrl.del_any) begin
      if (g && !left_g) begin
        val_next = new_val; age_next = '0; valid_next = 1'b1;
      end else if (g) begin
        val_next = left_val; age_next = left_age + AW'(1); valid_next = left_valid;
      end
    end else if (ctrl.del_low) begin
      if (del_at_or_before && !g) begin
        if (right_g) begin
          val_next = new_val; age_next = '0; valid_next = 1'b1;
        end else begin
          val_next = right_val; age_next = right_age + AW'(1); valid_next = right_valid;
        end
      end
    end else begin
      if (g && !left_g) begin
        val_next = new_val; age_next = '0; valid_next = 1'b1;
      end else if (g && !del_before) begin
        val_next = left_val; age_next = left_age + AW'(1); valid_next = left_valid;
      end
    end
  end

  // row state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.ins) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      val <= val_next;
      age <= age_next;
    end
  end

  // scan line stage
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      scan_val <= val;
      scan_act <= valid && (CW'(age) < win);
    end else if (ctrl.shift) begin
      scan_val <= scan_in_val;
      scan_act <= scan_in_act;
    end
  end

endmodule

/* hw/rtl/sliding_window_median_deviation_sum.sv */
// top level: sorted cell row, scan accumulator and stream ports
// a sample that fills the window is inserted, loaded to the scan line, scanned, then output
// throughput: while a result is made no sample is taken, else one sample per cycle
// sample intake waits on the scan line, which moves the row past one accumulator
// reset (rst, synchronous, active high) empties the row and sets window_size to 3
module sliding_window_median_deviation_sum #(
  parameter int WINDOW_MAX  = swmd_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swmd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [swmd_pkg::IN_TDATA_W-1:0]    s_tdata,   // [15:0] sample
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [swmd_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [20:0] window_cost, rest zero
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [swmd_pkg::CFG_DATA_W-1:0]    cfg_data   // [6:0] window_size
);
  import swmd_pkg::*;

  localparam int N       = WINDOW_MAX;
  localparam int SB      = SAMPLE_BITS;
  localparam int AW      = $clog2(N);
  localparam int CW      = $clog2(N + 1);
  localparam int ACC_RAW = SB + AW + 2;
  localparam int ACC_W   = (ACC_RAW > COST_W) ? ACC_RAW : COST_W;

  state_t state, state_next;
  cell_ctrl_t ctrl;

  logic [WSIZE_W-1:0] wsize;
  logic [CW-1:0]      win;
  logic [CW-1:0]      fill;
  logic [CW-1:0]      fill_next;
  logic [CW-1:0]      mid;
  logic [CW-1:0]      rank;
  logic [AW-1:0]      cnt;
  logic signed [ACC_W-1:0] acc;
  logic [COST_W-1:0]  cost;
  logic               s_acc;
  logic               scan_last;
  logic [SB-1:0]      new_val;

  logic [SB-1:0] c_val [N];
  logic [AW-1:0] c_age [N];
  logic [SB-1:0] sc_val [N];
  logic [N-1:0]  c_valid, c_g, c_del, sc_act, bd, ad;

  assign cfg_ready = 1'b1;
  assign s_acc     = s_tvalid && s_tready;
  assign new_val   = SB'(s_tdata);
  assign scan_last = (cnt == AW'(N - 1));

  // window size register
  always_ff @(posedge clk) begin
    if (rst) begin
      wsize <= WSIZE_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      wsize <= cfg_data[WSIZE_W-1:0];
    end
  end

  // effective window: zero acts as one, large values clamp
  always_comb begin
    if (wsize == '0) begin
      win = CW'(1);
    end else if (32'(wsize) > 32'(N)) begin
      win = CW'(N);
    end else begin
      win = CW'(wsize);
    end
  end
  assign mid = (win - CW'(1)) >> 1;

  assign fill_next = (fill == CW'(N)) ? fill : fill + CW'(1);

  // deletion position seen from each cell
  always_comb begin
    bd[0] = 1'b0;
    for (int i = 1; i < N; i++) begin
      bd[i] = bd[i-1] | c_del[i-1];
    end
    ad = bd | c_del;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_acc && (fill_next >= win)) state_next = ST_LOAD;
      ST_LOAD: state_next = ST_SCAN;
      ST_SCAN: if (scan_last) state_next = ST_DONE;
      ST_DONE: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready     = (state == ST_IDLE);
    ctrl.ins     = s_acc;
    ctrl.del_any = |c_del;
    ctrl.del_low = |(c_del & ~c_g);
    ctrl.load    = (state == ST_LOAD);
    ctrl.shift   = (state == ST_SCAN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      if (s_acc) fill <= fill_next;
    end
  end

  // the sorted row
  for (genvar i = 0; i < N; i++) begin : g_cell
    swmd_cell #(.SB(SB), .AW(AW), .CW(CW), .WMAX(N)) u_cell (
      .clk              (clk),
      .rst              (rst),
      .ctrl             (ctrl),
      .new_val          (new_val),
      .win              (win),
      .left_val         ((i == 0) ? c_val[0] : c_val[(i == 0) ? 0 : i-1]),
      .left_age         (c_age[(i == 0) ? 0 : i-1]),
      .left_valid       ((i == 0) ? 1'b0 : c_valid[(i == 0) ? 0 : i-1]),
      .left_g           ((i == 0) ? 1'b0 : c_g[(i == 0) ? 0 : i-1]),
      .right_val        (c_val[(i == N-1) ? N-1 : i+1]),
      .right_age        (c_age[(i == N-1) ? N-1 : i+1]),
      .right_valid      ((i == N-1) ? 1'b0 : c_valid[(i == N-1) ? N-1 : i+1]),
      .right_g          ((i == N-1) ? 1'b1 : c_g[(i == N-1) ? N-1 : i+1]),
      .del_before       (bd[i]),
      .del_at_or_before (ad[i]),
      .scan_in_val      ((i == N-1) ? '0 : sc_val[(i == N-1) ? N-1 : i+1]),
      .scan_in_act      ((i == N-1) ? 1'b0 : sc_act[(i == N-1) ? N-1 : i+1]),
      .val              (c_val[i]),
      .age              (c_age[i]),
      .valid            (c_valid[i]),
      .g                (c_g[i]),
      .del              (c_del[i]),
      .scan_val         (sc_val[i]),
      .scan_act         (sc_act[i])
    );
  end

  // accumulate signed deviations as the row passes cell zero
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      acc  <= '0;
      rank <= '0;
      cnt  <= '0;
    end else if (state == ST_SCAN) begin
      cnt <= cnt + AW'(1);
      if (sc_act[0]) begin
        rank <= rank + CW'(1);
        if ((rank < mid) || ((rank == mid) && !win[0])) begin
          acc <= acc - ACC_W'(sc_val[0]);
        end else if (rank > mid) begin
          acc <= acc + ACC_W'(sc_val[0]);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
      cost <= acc[COST_W-1:0];
    end
  end

  assign m_tdata = OUT_TDATA_W'(cost);

endmodule

/* hw/rtl/swmd_checker.sv */
// port-level checks for the median deviation sum block
module swmd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        cfg_ready
);
  import swmd_pkg::*;

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed under stall");

  // pad bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:21] == 3'b000)
    else $error("result pad bits set");

  // a result never appears right after a sample is taken
  a_gap: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !(m_tvalid && !$past(m_tvalid)))
    else $error("result too early");

  // configuration is always taken
  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port stalled");

endmodule

bind sliding_window_median_deviation_sum swmd_checker u_swmd_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_ready (cfg_ready)
);

/* tb/testbench.sv */
// self-checking testbench for the sliding window median deviation sum
`timescale 1ns / 100ps

module testbench;
  import swmd_pkg::*;

  localparam int WMAX      = WINDOW_MAX_DEF;
  localparam int IDLE_LIM  = 20000;
  localparam int TAIL_CYC  = 2 * WMAX + 10;

  logic                    clk;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [IN_TDATA_W-1:0]   s_tdata;   // [15:0] sample
  logic                    m_tvalid;
  logic                    m_tready;
  logic [OUT_TDATA_W-1:0]  m_tdata;   // [20:0] window_cost, rest zero
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_DATA_W-1:0]   cfg_data;  // [6:0] window_size

  sliding_window_median_deviation_sum u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // predictor state
  logic [SAMPLE_W-1:0] hist_ring [WMAX];
  int unsigned         seen_cnt;
  int unsigned         wr_slot;
  logic [WSIZE_W-1:0]  wsize_reg;

  logic [COST_W-1:0]   cost_q [$];
  int                  err_cnt;
  int                  result_cnt;
  int                  sample_cnt;
  int                  cfg_cnt;
  int                  idle_cycles;
  int                  m_hold;

  // directed rows: window size to set first (-1 none), sample, cost to expect (-1 predict)
  typedef struct {
    int wsz;
    int smp;
    int cost;
  } dir_row_t;

  function automatic int eff_window(logic [WSIZE_W-1:0] w);
    if (w == 0) return 1;
    if (w > WMAX) return WMAX;
    return int'(w);
  endfunction

  // push a sample into the predicted history, return 1 with cost when the window is full
  function automatic bit push_sample(logic [SAMPLE_W-1:0] smp, output logic [COST_W-1:0] cost);
    int w;
    int mid;
    longint unsigned vals [$];
    longint unsigned med;
    longint unsigned acc;
    hist_ring[wr_slot] = smp;
    wr_slot = (wr_slot + 1) % WMAX;
    if (seen_cnt < WMAX) seen_cnt++;
    w = eff_window(wsize_reg);
    cost = '0;
    if (seen_cnt < w) return 1'b0;
    for (int i = 0; i < w; i++) vals.push_back(hist_ring[(wr_slot + WMAX - 1 - i) % WMAX]);
    vals.sort();
    mid = (w - 1) / 2;
    med = vals[mid];
    acc = 0;
    foreach (vals[i]) acc += (vals[i] > med) ? vals[i] - med : med - vals[i];
    cost = acc[COST_W-1:0];
    return 1'b1;
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  task automatic write_window(logic [CFG_DATA_W-1:0] val);
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    wsize_reg = val[WSIZE_W-1:0];
    cfg_cnt++;
  endtask

  // wait for all expected words, then let the block settle
  task automatic drain_and_settle();
    s_tvalid <= 1'b0;
    while (cost_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
  endtask

  // valid stays up after a word is taken; in this task it drops only for a gap
  task automatic send_sample(logic [SAMPLE_W-1:0] smp, int cost_lit);
    logic [COST_W-1:0] c;
    int g;
    g = rand_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tdata  <= smp;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sample_cnt++;
    if (push_sample(smp, c)) begin
      if (cost_lit >= 0 && c != cost_lit[COST_W-1:0]) begin
        $error("directed row disagrees: window_cost typed %0d predicted %0d", cost_lit, c);
        err_cnt++;
      end
      cost_q.push_back(c);
    end else if (cost_lit >= 0) begin
      $error("directed row expects a word but none predicted");
      err_cnt++;
    end
  endtask

  // result side: random stalls and field check
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      m_hold   <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (cost_q.size() == 0) begin
          $error("unexpected word: window_cost actual %0d", m_tdata[COST_W-1:0]);
          err_cnt++;
        end else begin
          logic [COST_W-1:0] exp_c;
          exp_c = cost_q.pop_front();
          if (m_tdata[COST_W-1:0] !== exp_c) begin
            $error("window_cost expected %0d actual %0d", exp_c, m_tdata[COST_W-1:0]);
            err_cnt++;
          end
        end
        result_cnt++;
      end
      if (m_hold > 0) begin
        m_hold   <= m_hold - 1;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        m_hold   <= rand_gap();
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIM) begin
      $display("watchdog: no traffic for %0d cycles", IDLE_LIM);
      $display("*** FAILED ***");
      $finish;
    end
  end

  dir_row_t dir_rows [$];
  int wsizes [] = '{1, 2, 3, 5, 8, 16, 31, 64};

  initial begin
    int phase_len;
    int mode;
    int w;
    logic [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0] v;
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0;
    cfg_valid = 1'b0; cfg_data = '0;
    err_cnt = 0; result_cnt = 0; sample_cnt = 0; cfg_cnt = 0;
    seen_cnt = 0; wr_slot = 0; wsize_reg = 3;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: default window, fill, extremes, window of one / zero / too large, resize
    dir_rows = '{
      '{-1, 0, -1}, '{-1, 65535, -1}, '{-1, 0, 65535},
      '{-1, 65535, 65535}, '{-1, 65535, 65535}, '{-1, 65535, 0},
      '{1, 12345, 0}, '{-1, 65535, 0}, '{0, 7, 0}, '{-1, 0, 0},
      '{2, 65535, 65535}, '{-1, 65535, 0},
      '{127, 1, -1}, '{-1, 2, -1}, '{64, 65535, -1}, '{-1, 0, -1},
      '{4, 10, -1}, '{-1, 20, -1}, '{-1, 30, -1}, '{-1, 40, -1}
    };
    foreach (dir_rows[i]) begin
      if (dir_rows[i].wsz >= 0) begin
        drain_and_settle();
        write_window(dir_rows[i].wsz[CFG_DATA_W-1:0]);
      end
      send_sample(dir_rows[i].smp[SAMPLE_W-1:0], dir_rows[i].cost);
    end

    // random phases with a new window each, held until the queue empties
    while (sample_cnt < 1200) begin
      drain_and_settle();
      if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 127);
      else if ($urandom_range(0, 9) == 0) w = 64;
      else w = wsizes[$urandom_range(0, 5)];
      write_window(w[CFG_DATA_W-1:0]);
      phase_len = (eff_window(w[WSIZE_W-1:0]) > 16) ? $urandom_range(10, 40)
                                                    : $urandom_range(30, 120);
      mode = $urandom_range(0, 3);
      base = SAMPLE_W'($urandom);
      for (int k = 0; k < phase_len; k++) begin
        case (mode)
          0: v = SAMPLE_W'($urandom);
          1: v = base + SAMPLE_W'($urandom_range(0, 15));
          2: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          default: v = ($urandom_range(0, 3) == 0) ? SAMPLE_W'($urandom) : base;
        endcase
        send_sample(v, -1);
        // sender holds off until the result side catches up
        if (k == phase_len / 2 && $urandom_range(0, 3) == 0) begin
          s_tvalid <= 1'b0;
          do @(posedge clk); while (cost_q.size() != 0);
        end
      end
    end

    drain_and_settle();
    $display("covered %0d samples, %0d result words, %0d window writes",
             sample_cnt, result_cnt, cfg_cnt);
    if (err_cnt == 0 && cost_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/swmd_pkg.sv
hw/rtl/swmd_cell.sv
hw/rtl/sliding_window_median_deviation_sum.sv
hw/rtl/swmd_checker.sv
tb/testbench.sv
